// ===== rtl/core/run_length_byte_decoder_unit_defines.svh =====
// Assertion macros for the run-length byte decoder unit.
`ifndef RUN_LENGTH_BYTE_DECODER_UNIT_DEFINES_SVH
`define RUN_LENGTH_BYTE_DECODER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RLBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RLBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RLBD_ASSERT(lbl, prop, msg)
`define RLBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rlbd_pkg.sv =====
// Shared constants and control types of the run-length byte decoder.
`timescale 1ns / 1ps
package rlbd_pkg;
	localparam int BYTE_W = 8;
	localparam int RUN_W = 7;
	localparam int LIMIT_W = 13;
	localparam int CNT_W = 3;
	localparam int LANES = 4;
	localparam int DATA_W = BYTE_W * LANES;
	localparam int TDATA_W = 40;
	localparam int TUSER_W = 4;

	localparam logic [BYTE_W-1:0] TOP_BIT = 8'h80;
	localparam logic [RUN_W-1:0] MAX_RUN = 7'h7f;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'h1340;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LITERAL = 2'd1;
	localparam logic [1:0] PH_REPEAT = 2'd2;
	localparam logic [1:0] PH_TAIL = 2'd3;

	typedef struct packed {
		logic decode;
		logic emit;
	} rlbd_cmd_t;

	typedef struct packed {
		logic has_res;
		logic gen_final;
		logic out_free;
	} rlbd_stat_t;
endpackage

// ===== rtl/core/rlbd_ctrl.sv =====
// Controller state machine: sequences decode and result beat generation.
`timescale 1ns / 1ps
module rlbd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rlbd_pkg::rlbd_stat_t stat,
	output rlbd_pkg::rlbd_cmd_t  cmd
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_GEN = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.decode = in_valid;
				if (in_valid && stat.has_res) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				cmd.emit = stat.out_free;
				if (stat.out_free && stat.gen_final) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/core/rlbd_datapath.sv =====
// Datapath: decoder state, byte keeping against the limit, beat packing and output register.
`timescale 1ns / 1ps
module rlbd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rlbd_pkg::LIMIT_W-1:0]      cfg_wdata,
	input  logic [rlbd_pkg::BYTE_W-1:0]       in_byte,
	input  logic                              start_req,
	input  logic                              last_byte,
	input  rlbd_pkg::rlbd_cmd_t               cmd,
	output rlbd_pkg::rlbd_stat_t              stat,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [rlbd_pkg::TDATA_W-1:0]      m_tdata,
	output logic [rlbd_pkg::TUSER_W-1:0]      m_tuser,
	output logic                              m_tlast
);
	logic [1:0] phase_q;
	logic [rlbd_pkg::RUN_W-1:0] remaining_q;
	logic [rlbd_pkg::LIMIT_W-1:0] image_count_q;
	logic overflowed_q;
	logic [rlbd_pkg::LIMIT_W-1:0] limit_q;

	logic [rlbd_pkg::RUN_W-1:0] gen_left_q;
	logic [rlbd_pkg::BYTE_W-1:0] gen_byte_q;
	logic gen_tail_q;
	logic gen_last_q;
	logic gen_done_q;

	logic m_valid_q;
	logic [rlbd_pkg::TDATA_W-1:0] m_data_q;
	logic [rlbd_pkg::TUSER_W-1:0] m_user_q;
	logic m_last_q;

	logic [1:0] ph_eff;
	logic [rlbd_pkg::RUN_W-1:0] rem_eff;
	logic [rlbd_pkg::LIMIT_W-1:0] cnt_eff;
	logic ovf_eff;
	logic [rlbd_pkg::LIMIT_W-1:0] avail;
	logic [1:0] ph_d;
	logic [rlbd_pkg::RUN_W-1:0] rem_d;
	logic [rlbd_pkg::RUN_W-1:0] keep;
	logic ovf_d;
	logic tail_d;
	logic term_d;

	logic [rlbd_pkg::CNT_W-1:0] beat_cnt;
	logic beat_final;
	logic [rlbd_pkg::DATA_W-1:0] beat_data;

	always_comb begin
		ph_eff = start_req ? rlbd_pkg::PH_HEADER : phase_q;
		rem_eff = start_req ? '0 : remaining_q;
		cnt_eff = start_req ? '0 : image_count_q;
		ovf_eff = start_req ? 1'b0 : overflowed_q;
		avail = (cnt_eff < limit_q) ? (limit_q - cnt_eff) : '0;
		ph_d = ph_eff;
		rem_d = rem_eff;
		keep = '0;
		ovf_d = ovf_eff;
		tail_d = 1'b0;
		term_d = 1'b0;
		unique case (ph_eff)
			rlbd_pkg::PH_HEADER: begin
				rem_d = in_byte[rlbd_pkg::RUN_W-1:0] & rlbd_pkg::MAX_RUN;
				if (in_byte == '0) begin
					ph_d = rlbd_pkg::PH_TAIL;
					term_d = 1'b1;
				end else if ((in_byte & rlbd_pkg::TOP_BIT) != '0) begin
					ph_d = (rem_d != '0) ? rlbd_pkg::PH_LITERAL : rlbd_pkg::PH_HEADER;
				end else begin
					ph_d = rlbd_pkg::PH_REPEAT;
				end
			end
			rlbd_pkg::PH_LITERAL: begin
				if (avail != '0) begin
					keep = rlbd_pkg::RUN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
				rem_d = rem_eff - rlbd_pkg::RUN_W'(1);
				if (rem_d == '0) begin
					ph_d = rlbd_pkg::PH_HEADER;
				end
			end
			rlbd_pkg::PH_REPEAT: begin
				if (rlbd_pkg::LIMIT_W'(rem_eff) <= avail) begin
					keep = rem_eff;
				end else begin
					keep = avail[rlbd_pkg::RUN_W-1:0];
					ovf_d = 1'b1;
				end
				rem_d = '0;
				ph_d = rlbd_pkg::PH_HEADER;
			end
			rlbd_pkg::PH_TAIL: begin
				keep = rlbd_pkg::RUN_W'(1);
				tail_d = 1'b1;
			end
			default: begin
				ph_d = rlbd_pkg::PH_HEADER;
			end
		endcase
	end

	always_comb begin
		beat_final = (gen_left_q <= rlbd_pkg::RUN_W'(rlbd_pkg::LANES));
		beat_cnt = beat_final ? gen_left_q[rlbd_pkg::CNT_W-1:0] : rlbd_pkg::CNT_W'(rlbd_pkg::LANES);
		for (int i = 0; i < rlbd_pkg::LANES; i++) begin
			beat_data[i*rlbd_pkg::BYTE_W +: rlbd_pkg::BYTE_W] =
				(rlbd_pkg::CNT_W'(i) < beat_cnt) ? gen_byte_q : '0;
		end
	end

	assign stat.has_res = (keep != '0) || term_d || last_byte;
	assign stat.gen_final = beat_final;
	assign stat.out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rlbd_pkg::PH_HEADER;
			remaining_q <= '0;
			image_count_q <= '0;
			overflowed_q <= 1'b0;
			limit_q <= rlbd_pkg::LIMIT_RESET;
			gen_left_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.decode) begin
				phase_q <= ph_d;
				remaining_q <= rem_d;
				overflowed_q <= ovf_d;
				gen_left_q <= keep;
				if (!tail_d) begin
					image_count_q <= cnt_eff + rlbd_pkg::LIMIT_W'(keep);
				end else begin
					image_count_q <= cnt_eff;
				end
			end else if (cmd.emit) begin
				gen_left_q <= gen_left_q - rlbd_pkg::RUN_W'(beat_cnt);
			end
			if (cmd.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			gen_byte_q <= in_byte;
			gen_tail_q <= tail_d;
			gen_last_q <= last_byte;
			gen_done_q <= (ph_d == rlbd_pkg::PH_TAIL);
		end
		if (cmd.emit) begin
			m_data_q <= {5'b0, beat_cnt, beat_data};
			m_user_q <= {beat_final && gen_last_q, overflowed_q, gen_done_q, gen_tail_q};
			m_last_q <= beat_final;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;
	assign m_tlast = m_last_q;
endmodule

// ===== rtl/core/run_length_byte_decoder_unit.sv =====
// Top level of the packbits-style run-length byte decoder.
// Each accepted byte is decoded first, then its result beats are generated while the
// output is free: a kept literal byte and a tail byte yield one beat, a dropped literal
// byte or a header yields one only at the stream end or for the zero header, and a repeat
// of N kept bytes yields ceil(N / 4) beats (one when none is kept but the stream ends), 32 at most.
// The beat generator in the datapath packs one beat per cycle while the output is free;
// back pressure on the master side stalls it. A new byte is taken while the last beat
// of the previous byte still waits in the output register.
`timescale 1ns / 1ps
`include "run_length_byte_decoder_unit_defines.svh"
module run_length_byte_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rlbd_pkg::LIMIT_W-1:0]      cfg_wdata,  // image_limit
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rlbd_pkg::BYTE_W-1:0]       s_tdata,    // in_byte
	input  logic [0:0]                        s_tuser,    // start_req
	input  logic                              s_tlast,    // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rlbd_pkg::TDATA_W-1:0]      m_tdata,    // out_data, out_count, zero pad
	output logic [rlbd_pkg::TUSER_W-1:0]      m_tuser,    // tail_part, image_done, overflow, stream_end
	output logic                              m_tlast     // run_last
);
	rlbd_pkg::rlbd_cmd_t cmd;
	rlbd_pkg::rlbd_stat_t stat;

	rlbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rlbd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_byte   (s_tdata),
		.start_req (s_tuser[0]),
		.last_byte (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	`RLBD_ASSERT(a_emit_free, !cmd.emit || stat.out_free, "beat emitted into a full output register")
	`RLBD_ASSERT(a_no_overlap, !(cmd.emit && cmd.decode), "decode and emit in the same cycle")
	`RLBD_ASSERT(a_count_range, !m_tvalid || (m_tdata[34:32] <= 3'd4), "beat count above four")
	`RLBD_ASSERT(a_empty_final, !m_tvalid || (m_tdata[34:32] != 3'd0) || m_tlast, "empty beat not final")
	`RLBD_ASSERT_NEXT(a_gen_busy, cmd.decode && stat.has_res, !s_tready, "input taken during beat generation")
endmodule
